FILE: design/rtt_pkg.sv
// Shared types, codes and defaults for the response tag tracker.
package rtt_pkg;

  // Widths of the command and result fields.
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned TAG_W     = 4;
  localparam int unsigned PAYLOAD_W = 64;

  // Defaults for the top-level parameters.
  localparam int unsigned TAG_COUNT_DEF  = 16;
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_PACKET  = 2'd1,
    CMD_COLLECT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED    = 3'd0,
    ST_ALL_BUSY   = 3'd1,
    ST_TO_MASTER  = 3'd2,
    ST_TO_QUEUE   = 3'd3,
    ST_STORED     = 3'd4,
    ST_UNEXPECTED = 3'd5,
    ST_DELIVERED  = 3'd6,
    ST_PENDING    = 3'd7
  } status_e;

endpackage

FILE: design/rtt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rtt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/response_tag_tracker.sv
// Top level of the response tag tracker: command decode, tag marks and result register.
//
// The tracker hands out request tags and matches responses to them.
// A command is issued by raising start_i with command_i, is_response_i,
// is_master_i, tag_i and payload_i; it is taken on any rising edge where
// start_i is high and busy_o is low. busy_o stays low, so one command is
// taken in every cycle.
// Each command yields exactly one result on status_o, tag_out_o and
// data_out_o, shown for a single cycle while done_o is high. The result
// passes through the input register (while the response store is read)
// and then the result register. Results leave in command order at one
// per cycle; the receiver cannot stall them and must take each one as it
// is shown.
// Allocate grants the lowest free tag or reports all busy; a received
// response is stored under its tag if that tag is waiting; collect returns
// the stored data and frees the tag, or reports pending.
// Reset clears the waiting and received marks and the pipeline valid
// flags. The response store is not cleared: an entry is read only after
// its tag has received a response, which writes the entry first.
module response_tag_tracker #(
  parameter int unsigned TAG_COUNT  = rtt_pkg::TAG_COUNT_DEF,
  parameter int unsigned DATA_WIDTH = rtt_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [rtt_pkg::CMD_W-1:0]      command_i,
  input  logic                           is_response_i,
  input  logic                           is_master_i,
  input  logic [rtt_pkg::TAG_W-1:0]      tag_i,
  input  logic [rtt_pkg::PAYLOAD_W-1:0]  payload_i,
  output logic                           done_o,
  output logic [rtt_pkg::STATUS_W-1:0]   status_o,
  output logic [rtt_pkg::TAG_W-1:0]      tag_out_o,
  output logic [rtt_pkg::PAYLOAD_W-1:0]  data_out_o
);

  import rtt_pkg::*;

  localparam int unsigned IDX_W = $clog2(TAG_COUNT);

  // Input register.
  logic                  in_vld_q;
  cmd_e                  cmd_q;
  logic                  is_resp_q;
  logic                  is_mast_q;
  logic [TAG_W-1:0]      tag_q;
  logic [DATA_WIDTH-1:0] pay_q;

  // Tag marks.
  logic [TAG_COUNT-1:0] wait_q, wait_d;
  logic [TAG_COUNT-1:0] recv_q, recv_d;

  // Result register.
  logic                 res_vld_q;
  status_e              status_q, status_d;
  logic [TAG_W-1:0]     tag_out_q, tag_out_d;
  logic [PAYLOAD_W-1:0] data_q, data_d;

  // Store access and read bypass.
  logic                  accept;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  byp_hit_q;
  logic [DATA_WIDTH-1:0] byp_data_q;
  logic [DATA_WIDTH-1:0] rd_data;

  // Decode helpers.
  logic                 tag_ok;
  logic [IDX_W-1:0]     tag_idx;
  logic [TAG_COUNT-1:0] tag_oh;
  logic [TAG_COUNT-1:0] free_bits;
  logic [TAG_COUNT-1:0] grant_oh;
  logic [IDX_W-1:0]     grant_idx;

  // Commands are taken in every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Input register: control flag under reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_e'(command_i);
      is_resp_q <= is_response_i;
      is_mast_q <= is_master_i;
      tag_q     <= tag_i;
      pay_q     <= DATA_WIDTH'(payload_i);
    end
  end

  // Response store, read as the command is taken.
  assign rd_idx = IDX_W'(tag_i);

  rtt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (TAG_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (pay_q),
    .re_i    (accept),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // A response stored by the command ahead lands on the same edge as the
  // read; catch it here so the next command sees the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (accept) begin
      byp_hit_q <= wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byp_data_q <= pay_q;
    end
  end

  assign rd_data = byp_hit_q ? byp_data_q : ram_rdata;

  // Tag range check and one-hot form of the command's tag.
  assign tag_ok  = 32'(tag_q) < 32'(TAG_COUNT);
  assign tag_idx = IDX_W'(tag_q);
  assign tag_oh  = tag_ok ? (TAG_COUNT'(1) << tag_idx) : '0;

  // Lowest free tag: isolate the lowest set bit, then encode it.
  assign free_bits = ~wait_q;
  assign grant_oh  = free_bits & (~free_bits + TAG_COUNT'(1));

  always_comb begin
    grant_idx = '0;
    for (int i = 0; i < int'(TAG_COUNT); i++) begin
      if (grant_oh[i]) begin
        grant_idx = grant_idx | IDX_W'(i);
      end
    end
  end

  // Command decode: next marks, store write and the result.
  always_comb begin
    wait_d    = wait_q;
    recv_d    = recv_q;
    wr_en     = 1'b0;
    wr_idx    = tag_idx;
    status_d  = ST_PENDING;
    tag_out_d = tag_q;
    data_d    = '0;
    case (cmd_q)
      CMD_ALLOC: begin
        if (free_bits == '0) begin
          status_d  = ST_ALL_BUSY;
          tag_out_d = '0;
        end else begin
          status_d  = ST_GRANTED;
          tag_out_d = TAG_W'(grant_idx);
          wait_d    = wait_q | grant_oh;
          recv_d    = recv_q & ~grant_oh;
        end
      end
      CMD_PACKET: begin
        if (!is_resp_q) begin
          status_d = is_mast_q ? ST_TO_MASTER : ST_TO_QUEUE;
        end else if ((wait_q & tag_oh) == '0) begin
          status_d = ST_UNEXPECTED;
        end else begin
          status_d = ST_STORED;
          wr_en    = in_vld_q;
          recv_d   = recv_q | tag_oh;
        end
      end
      CMD_COLLECT: begin
        if ((recv_q & tag_oh) != '0) begin
          status_d = ST_DELIVERED;
          data_d   = PAYLOAD_W'(rd_data);
          recv_d   = recv_q & ~tag_oh;
          wait_d   = wait_q & ~tag_oh;
        end
      end
      default: begin
        status_d = ST_PENDING;
      end
    endcase
  end

  // Marks change only for a command in the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= '0;
      recv_q <= '0;
    end else if (in_vld_q) begin
      wait_q <= wait_d;
      recv_q <= recv_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      status_q  <= status_d;
      tag_out_q <= tag_out_d;
      data_q    <= data_d;
    end
  end

  assign done_o     = res_vld_q;
  assign status_o   = status_q;
  assign tag_out_o  = tag_out_q;
  assign data_out_o = data_q;

  // Every command transfer yields a result after the input and result registers.
  a_result_follows : assert property (
    @(posedge clk_i) disable iff (!rst_ni) accept |=> ##1 done_o
  ) else $error("command transfer without a matching result");

  // A tag can only hold a received response while it is waiting.
  a_recv_subset : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (recv_q & ~wait_q) == '0
  ) else $error("received mark set on a tag that is not waiting");

  // All busy is only reported when every tag is waiting.
  a_all_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (done_o && status_q == ST_ALL_BUSY) |-> (&wait_q)
  ) else $error("all busy reported while a tag is free");

  // Data is only driven for a delivered response.
  a_data_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (done_o && status_q != ST_DELIVERED) |-> (data_q == '0)
  ) else $error("result data non-zero without a delivery");

endmodule
